/* design/dexp_pkg.sv */
// shared types and codes for the decimal exponent number alu
`default_nettype none

package dexp_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  // order codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;
  localparam logic [1:0] ORD_UN = 2'd3;

  // width of the digit shift counters (scale count, quotient adjust)
  localparam int ADJ_W = 8;

  // request to the divide-by-ten unit
  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  // status from the divide-by-ten unit
  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/dexp_if.sv */
// input and result channel interfaces of the decimal exponent number alu
`default_nettype none

interface dexp_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   operation;
  logic signed [DATA_WIDTH-1:0] a_significand;
  logic signed [DATA_WIDTH-1:0] a_exponent;
  logic signed [DATA_WIDTH-1:0] b_significand;
  logic signed [DATA_WIDTH-1:0] b_exponent;

  modport source (
    output valid, operation, a_significand, a_exponent, b_significand, b_exponent,
    input  ready
  );
  modport sink (
    input  valid, operation, a_significand, a_exponent, b_significand, b_exponent,
    output ready
  );
endinterface

interface dexp_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_significand;
  logic signed [DATA_WIDTH-1:0] r_exponent;
  logic [1:0]                   order;

  modport source (
    output valid, r_significand, r_exponent, order,
    input  ready
  );
  modport sink (
    input  valid, r_significand, r_exponent, order,
    output ready
  );
endinterface

`default_nettype wire

/* design/dexp_div10.sv */
// nibble-serial divide-by-ten unit with remainder
`default_nettype none

module dexp_div10
  import dexp_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  localparam int PW = ((2 * DATA_WIDTH + 3) / 4) * 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  input  wire logic [PW-1:0] din,
  output      div_rsp_t      rsp,
  output      logic [PW-1:0] quo
);

  localparam int SW = ((DATA_WIDTH + 3) / 4) * 4;
  localparam int CW = $clog2(PW / 4 + 1);

  logic [PW-1:0] dv_r, dv_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [7:0]  cur;
  logic [14:0] prod;
  logic [3:0]  qn;
  logic [7:0]  rn;

  // one decimal digit step: cur < 160, q = cur * 205 >> 11
  assign cur  = {rem_r, dv_r[PW-1 -: 4]};
  assign prod = {7'd0, cur} * 15'd205;
  assign qn   = prod[14:11];
  assign rn   = cur - {1'b0, qn, 3'b000} - {3'b000, qn, 1'b0};

  always_comb begin
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = 4'd0;
      busy_nxt = 1'b1;
      if (req.wide) begin
        dv_nxt  = din;
        cnt_nxt = CW'(PW / 4);
      end else begin
        dv_nxt  = {din[SW-1:0], {(PW - SW){1'b0}}};
        cnt_nxt = CW'(SW / 4);
      end
    end else if (busy_r) begin
      dv_nxt  = {dv_r[PW-5:0], qn};
      rem_nxt = rn[3:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign quo      = dv_r;

endmodule

`default_nettype wire

/* design/decimal_exponent_number_alu.sv */
// top level of the decimal exponent number alu
`default_nettype none

// Decimal exponent number alu. A number is a signed significand times ten to
// a signed exponent; the largest exponent marks NaN (significand zero) or an
// infinity. One word in gives one word out: add, subtract, multiply, divide
// (each result stripped of trailing decimal zeros) or an order code. The
// block works on one word at a time: in_port.ready is high only while idle,
// and the result waits in its register until out_port takes it. Latency
// varies with the data and is set mostly by the shared nibble-serial
// divide-by-ten unit, which steps through the significand a nibble at a time
// (through the double-width product when scaling a product down). It is
// called through a wait state for each trailing-zero test, each truncated
// alignment or overflow digit, each product digit and each compare. The
// shift-add multiplier takes one multiplier bit per pass, and long division
// takes up to nine subtracts and one digit step per quotient digit.
// No memories.

module decimal_exponent_number_alu
  import dexp_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dexp_in_if.sink   in_port,
  dexp_out_if.source out_port
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = ((2 * W + 3) / 4) * 4;
  localparam int DW = W + 4;

  localparam logic signed [W-1:0] EMAX    = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] EMAX_M1 = {1'b0, {(W - 2){1'b1}}, 1'b0};
  localparam logic signed [W-1:0] SMIN    = {1'b1, {(W - 1){1'b0}}};
  localparam logic [W-1:0]  SMAX_U = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]  SMIN_U = {1'b1, {(W - 1){1'b0}}};
  // magnitude bounds for a times-ten that stays in range
  localparam logic [W-1:0]  MUL_HI = SMAX_U / W'(10);
  localparam logic [W-1:0]  MUL_LO = SMIN_U / W'(10);
  localparam logic [DW-1:0] Q_MAX  = DW'(SMAX_U);
  localparam logic [DW-1:0] Q_LIM  = DW'(MUL_HI);

  // sequencer states
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_NA    = 6'd1;
  localparam logic [5:0] S_NB    = 6'd2;
  localparam logic [5:0] S_SUBR  = 6'd3;
  localparam logic [5:0] S_ADD   = 6'd4;
  localparam logic [5:0] S_AL1   = 6'd5;
  localparam logic [5:0] S_AL2   = 6'd6;
  localparam logic [5:0] S_AL3   = 6'd7;
  localparam logic [5:0] S_AL3P  = 6'd8;
  localparam logic [5:0] S_AL4   = 6'd9;
  localparam logic [5:0] S_AL4P  = 6'd10;
  localparam logic [5:0] S_OVF   = 6'd11;
  localparam logic [5:0] S_OVFA  = 6'd12;
  localparam logic [5:0] S_OVFB  = 6'd13;
  localparam logic [5:0] S_MUL   = 6'd14;
  localparam logic [5:0] S_MULI  = 6'd15;
  localparam logic [5:0] S_MULF  = 6'd16;
  localparam logic [5:0] S_MULFP = 6'd17;
  localparam logic [5:0] S_MULE  = 6'd18;
  localparam logic [5:0] S_DIV   = 6'd19;
  localparam logic [5:0] S_DV1   = 6'd20;
  localparam logic [5:0] S_DV2   = 6'd21;
  localparam logic [5:0] S_DV3   = 6'd22;
  localparam logic [5:0] S_DIVE  = 6'd23;
  localparam logic [5:0] S_CMP   = 6'd24;
  localparam logic [5:0] S_CML   = 6'd25;
  localparam logic [5:0] S_NORM  = 6'd26;
  localparam logic [5:0] S_NORMP = 6'd27;
  localparam logic [5:0] S_DWAIT = 6'd28;
  localparam logic [5:0] S_DONE  = 6'd29;

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic logic signed [W-1:0] sgn_f(input logic neg, input logic [W-1:0] q);
    return neg ? (~q + W'(1)) : q;
  endfunction

  function automatic logic [1:0] swap_ord(input logic [1:0] o);
    logic [1:0] r;
    r = o;
    if (o == ORD_LT) r = ORD_GT;
    else if (o == ORD_GT) r = ORD_LT;
    return r;
  endfunction

  // sequencer and subroutine return points
  logic [5:0] state_r, state_nxt;
  logic [5:0] ret_r, ret_nxt;
  logic [5:0] dret_r, dret_nxt;
  logic [2:0] op_r, op_nxt;

  // operands, alignment copy and result / normalize register
  logic signed [W-1:0] as_r, as_nxt, ae_r, ae_nxt;
  logic signed [W-1:0] bs_r, bs_nxt, be_r, be_nxt;
  logic signed [W-1:0] be0_r, be0_nxt;
  logic signed [W-1:0] ns_r, ns_nxt, ne_r, ne_nxt;
  logic [1:0]          ord_r, ord_nxt;
  logic                neg_r, neg_nxt;

  // multiply
  logic [2*W-1:0]   acc_r, acc_nxt, mc_r, mc_nxt;
  logic [W-1:0]     mp_r, mp_nxt;
  logic [ADJ_W-1:0] k_r, k_nxt;

  // long division
  logic [DW-1:0]    sa_r, sa_nxt, sb_r, sb_nxt, q_r, q_nxt, qp_r, qp_nxt;
  logic [ADJ_W-1:0] adj_r, adj_nxt;

  // compare
  logic [W-1:0] ma_r, ma_nxt, mb_r, mb_nxt, d_r, d_nxt;
  logic         flip_r, flip_nxt;

  // shared divide-by-ten unit
  div_req_t      div_req;
  div_rsp_t      div_rsp;
  logic [PW-1:0] div_din;
  logic [PW-1:0] div_quo;

  dexp_div10 #(.DATA_WIDTH(W)) u_div10 (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .din  (div_din),
    .rsp  (div_rsp),
    .quo  (div_quo)
  );

  logic in_fire;
  assign in_fire = in_port.valid && in_port.ready;

  // operand class
  logic a_nan, a_inf, b_nan, b_inf;
  assign a_nan = (ae_r == EMAX) && (as_r == '0);
  assign a_inf = (ae_r == EMAX) && (as_r != '0);
  assign b_nan = (be_r == EMAX) && (bs_r == '0);
  assign b_inf = (be_r == EMAX) && (bs_r != '0);

  // times-ten and its range check
  logic signed [W-1:0] as10, bs10;
  logic                ovf10_a, ovf10_b;
  assign as10    = (as_r <<< 3) + (as_r <<< 1);
  assign bs10    = (bs_r <<< 3) + (bs_r <<< 1);
  assign ovf10_a = as_r[W-1] ? (mag_f(as_r) > MUL_LO) : ($unsigned(as_r) > MUL_HI);
  assign ovf10_b = bs_r[W-1] ? (mag_f(bs_r) > MUL_LO) : ($unsigned(bs_r) > MUL_HI);

  // aligned sum
  logic [W:0] sum_x;
  logic       add_ovf;
  assign sum_x   = {as_r[W-1], as_r} + {bs_r[W-1], bs_r};
  assign add_ovf = sum_x[W] ^ sum_x[W-1];

  // divider quotient, re-signed
  logic [W-1:0]        dq_w;
  logic signed [W-1:0] sq_a, sq_b, sq_n;
  assign dq_w = div_quo[W-1:0];
  assign sq_a = sgn_f(as_r[W-1], dq_w);
  assign sq_b = sgn_f(bs_r[W-1], dq_w);
  assign sq_n = sgn_f(ns_r[W-1], dq_w);

  // product exponent: a + b, then + scale count, each range checked
  logic [W:0]   me1, me2;
  logic [W-1:0] mul_exp;
  assign me1 = {ae_r[W-1], ae_r} + {be_r[W-1], be_r};
  assign me2 = {me1[W-1], me1[W-1:0]} + {{(W + 1 - ADJ_W){k_r[ADJ_W-1]}}, k_r};
  assign mul_exp = ((me1[W] ^ me1[W-1]) || (me2[W] ^ me2[W-1])) ? EMAX : me2[W-1:0];

  // quotient exponent: a - b, then - adjust
  logic [W:0]   de1, de2;
  logic [W-1:0] div_exp;
  assign de1 = {ae_r[W-1], ae_r} - {be_r[W-1], be_r};
  assign de2 = {de1[W-1], de1[W-1:0]} - {{(W + 1 - ADJ_W){adj_r[ADJ_W-1]}}, adj_r};
  assign div_exp = ((de1[W] ^ de1[W-1]) || (de2[W] ^ de2[W-1])) ? EMAX : de2[W-1:0];

  // long division scaling
  logic [DW-1:0] sa10, q10;
  logic [DW+3:0] sb10x;
  assign sa10  = (sa_r << 3) + (sa_r << 1);
  assign q10   = (q_r << 3) + (q_r << 1);
  assign sb10x = ({4'd0, sb_r} << 3) + ({4'd0, sb_r} << 1);

  logic [W-1:0] ma10;
  assign ma10 = (ma_r << 3) + (ma_r << 1);

  logic neg_c;
  assign neg_c = as_r[W-1] ^ bs_r[W-1];

  // rank for infinities (neg inf, finite, pos inf) and for finite signs
  logic [1:0] ri_a, ri_b, rf_a, rf_b;
  assign ri_a = a_inf ? (as_r[W-1] ? 2'd0 : 2'd2) : 2'd1;
  assign ri_b = b_inf ? (bs_r[W-1] ? 2'd0 : 2'd2) : 2'd1;
  assign rf_a = as_r[W-1] ? 2'd0 : ((as_r == '0) ? 2'd1 : 2'd2);
  assign rf_b = bs_r[W-1] ? 2'd0 : ((bs_r == '0) ? 2'd1 : 2'd2);

  logic [1:0] cml_ord;
  assign cml_ord = (ma_r < mb_r) ? ORD_LT : ((ma_r > mb_r) ? ORD_GT : ORD_EQ);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    dret_nxt  = dret_r;
    op_nxt    = op_r;
    as_nxt    = as_r;
    ae_nxt    = ae_r;
    bs_nxt    = bs_r;
    be_nxt    = be_r;
    be0_nxt   = be0_r;
    ns_nxt    = ns_r;
    ne_nxt    = ne_r;
    ord_nxt   = ord_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    k_nxt     = k_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    q_nxt     = q_r;
    qp_nxt    = qp_r;
    adj_nxt   = adj_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    d_nxt     = d_r;
    flip_nxt  = flip_r;
    div_req   = '0;
    div_din   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_port.operation;
          bs_nxt    = in_port.b_significand;
          be_nxt    = in_port.b_exponent;
          ns_nxt    = in_port.a_significand;
          ne_nxt    = in_port.a_exponent;
          ret_nxt   = S_NA;
          state_nxt = S_NORM;
        end
      end
      // intake: strip both operands
      S_NA: begin
        as_nxt    = ns_r;
        ae_nxt    = ne_r;
        ns_nxt    = bs_r;
        ne_nxt    = be_r;
        ret_nxt   = S_NB;
        state_nxt = S_NORM;
      end
      S_NB: begin
        bs_nxt  = ns_r;
        be_nxt  = ne_r;
        ord_nxt = ORD_LT;
        case (op_r)
          OP_ADD: state_nxt = S_ADD;
          OP_SUB: begin
            // most negative significand negates to the most positive one
            ns_nxt    = (ns_r == SMIN) ? $signed(SMAX_U) : -ns_r;
            ret_nxt   = S_SUBR;
            state_nxt = S_NORM;
          end
          OP_MUL: state_nxt = S_MUL;
          OP_DIV: state_nxt = S_DIV;
          OP_CMP: state_nxt = S_CMP;
          default: begin
            ns_nxt    = '0;
            ne_nxt    = EMAX;
            ord_nxt   = ORD_UN;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SUBR: begin
        bs_nxt    = ns_r;
        be_nxt    = ne_r;
        state_nxt = S_ADD;
      end
      // add: specials first
      S_ADD: begin
        state_nxt = S_DONE;
        if (a_nan || b_nan || (a_inf && b_inf && (as_r[W-1] != bs_r[W-1]))) begin
          ns_nxt = '0;
          ne_nxt = EMAX;
        end else if (a_inf) begin
          ns_nxt = as_r;
          ne_nxt = ae_r;
        end else if (b_inf) begin
          ns_nxt = bs_r;
          ne_nxt = be_r;
        end else begin
          be0_nxt   = be_r;
          state_nxt = S_AL1;
        end
      end
      // scale the larger-exponent term up while it fits
      S_AL1: begin
        if ((ae_r > be0_r) && !ovf10_a) begin
          if (as_r == '0) begin
            ae_nxt    = be0_r;
            state_nxt = S_AL2;
          end else begin
            as_nxt = as10;
            ae_nxt = ae_r - W'(1);
          end
        end else begin
          state_nxt = S_AL2;
        end
      end
      S_AL2: begin
        if ((be_r > ae_r) && !ovf10_b) begin
          if (bs_r == '0) begin
            be_nxt    = ae_r;
            state_nxt = S_AL3;
          end else begin
            bs_nxt = bs10;
            be_nxt = be_r - W'(1);
          end
        end else begin
          state_nxt = S_AL3;
        end
      end
      // then truncate the other term down
      S_AL3: begin
        if ((ae_r < be_r) && (as_r != '0)) begin
          div_req.start = 1'b1;
          div_din       = PW'(mag_f(as_r));
          dret_nxt      = S_AL3P;
          state_nxt     = S_DWAIT;
        end else begin
          state_nxt = S_AL4;
        end
      end
      S_AL3P: begin
        as_nxt    = sq_a;
        ae_nxt    = ae_r + W'(1);
        state_nxt = S_AL3;
      end
      S_AL4: begin
        if ((be_r < ae_r) && (bs_r != '0)) begin
          div_req.start = 1'b1;
          div_din       = PW'(mag_f(bs_r));
          dret_nxt      = S_AL4P;
          state_nxt     = S_DWAIT;
        end else begin
          state_nxt = S_OVF;
        end
      end
      S_AL4P: begin
        bs_nxt    = sq_b;
        be_nxt    = be_r + W'(1);
        state_nxt = S_AL4;
      end
      // sum overflow: drop a digit from both terms
      S_OVF: begin
        if (add_ovf) begin
          if (ae_r == EMAX) begin
            ns_nxt    = as_r;
            ne_nxt    = ae_r;
            state_nxt = S_DONE;
          end else begin
            div_req.start = 1'b1;
            div_din       = PW'(mag_f(as_r));
            dret_nxt      = S_OVFA;
            state_nxt     = S_DWAIT;
          end
        end else begin
          ns_nxt    = sum_x[W-1:0];
          ne_nxt    = (ae_r > be_r) ? ae_r : be_r;
          ret_nxt   = S_DONE;
          state_nxt = S_NORM;
        end
      end
      S_OVFA: begin
        as_nxt        = sq_a;
        ae_nxt        = ae_r + W'(1);
        div_req.start = 1'b1;
        div_din       = PW'(mag_f(bs_r));
        dret_nxt      = S_OVFB;
        state_nxt     = S_DWAIT;
      end
      S_OVFB: begin
        bs_nxt    = sq_b;
        be_nxt    = be_r + W'(1);
        state_nxt = S_OVF;
      end
      // multiply
      S_MUL: begin
        neg_nxt = neg_c;
        if (a_nan || b_nan || ((a_inf || b_inf) && ((as_r == '0) || (bs_r == '0)))) begin
          ns_nxt    = '0;
          ne_nxt    = EMAX;
          state_nxt = S_DONE;
        end else if (a_inf || b_inf) begin
          ns_nxt    = neg_c ? '1 : W'(1);
          ne_nxt    = EMAX;
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = '0;
          mc_nxt    = {{W{1'b0}}, mag_f(as_r)};
          mp_nxt    = mag_f(bs_r);
          k_nxt     = '0;
          state_nxt = S_MULI;
        end
      end
      // shift-add, one multiplier bit a cycle
      S_MULI: begin
        if (mp_r != '0) begin
          if (mp_r[0]) acc_nxt = acc_r + mc_r;
          mc_nxt = mc_r << 1;
          mp_nxt = mp_r >> 1;
        end else begin
          state_nxt = S_MULF;
        end
      end
      // scale the product down until it fits
      S_MULF: begin
        if (acc_r[2*W-1:W-1] != '0) begin
          div_req.start = 1'b1;
          div_req.wide  = 1'b1;
          div_din       = PW'(acc_r);
          dret_nxt      = S_MULFP;
          state_nxt     = S_DWAIT;
        end else begin
          state_nxt = S_MULE;
        end
      end
      S_MULFP: begin
        acc_nxt   = div_quo[2*W-1:0];
        k_nxt     = k_r + ADJ_W'(1);
        state_nxt = S_MULF;
      end
      S_MULE: begin
        ns_nxt    = sgn_f(neg_r, acc_r[W-1:0]);
        ne_nxt    = mul_exp;
        ret_nxt   = S_DONE;
        state_nxt = S_NORM;
      end
      // divide: specials first
      S_DIV: begin
        neg_nxt   = neg_c;
        state_nxt = S_DONE;
        if (a_nan || b_nan || (a_inf && b_inf)) begin
          ns_nxt = '0;
          ne_nxt = EMAX;
        end else if (a_inf) begin
          ns_nxt = neg_c ? '1 : W'(1);
          ne_nxt = EMAX;
        end else if (b_inf) begin
          ns_nxt = '0;
          ne_nxt = '0;
        end else if (bs_r == '0) begin
          ns_nxt = as_r;
          ne_nxt = EMAX;
        end else if (as_r == '0) begin
          ns_nxt = '0;
          ne_nxt = '0;
        end else begin
          sa_nxt    = DW'(mag_f(as_r));
          sb_nxt    = DW'(mag_f(bs_r));
          adj_nxt   = '0;
          state_nxt = S_DV1;
        end
      end
      // line the divisor up under the dividend's leading digit
      S_DV1: begin
        if (sa_r < sb_r) begin
          sa_nxt  = sa10;
          adj_nxt = adj_r + ADJ_W'(1);
        end else begin
          state_nxt = S_DV2;
        end
      end
      S_DV2: begin
        if ({4'd0, sa_r} >= sb10x) begin
          sb_nxt  = sb10x[DW-1:0];
          adj_nxt = adj_r - ADJ_W'(1);
        end else begin
          q_nxt     = '0;
          qp_nxt    = '0;
          state_nxt = S_DV3;
        end
      end
      // one subtraction a cycle, one quotient digit per pass
      S_DV3: begin
        if (sa_r >= sb_r) begin
          sa_nxt = sa_r - sb_r;
          q_nxt  = q_r + DW'(1);
        end else if (q_r > Q_MAX) begin
          // digit would push past the most positive value: drop it
          q_nxt     = qp_r;
          adj_nxt   = adj_r - ADJ_W'(1);
          state_nxt = S_DIVE;
        end else if (((sa_r == '0) || (q_r > Q_LIM)) && !adj_r[ADJ_W-1]) begin
          state_nxt = S_DIVE;
        end else begin
          qp_nxt  = q_r;
          q_nxt   = q10;
          sa_nxt  = sa10;
          adj_nxt = adj_r + ADJ_W'(1);
        end
      end
      S_DIVE: begin
        ns_nxt    = sgn_f(neg_r, q_r[W-1:0]);
        ne_nxt    = div_exp;
        ret_nxt   = S_DONE;
        state_nxt = S_NORM;
      end
      // compare by true value
      S_CMP: begin
        ns_nxt    = '0;
        ne_nxt    = '0;
        state_nxt = S_DONE;
        if (a_nan || b_nan) begin
          ord_nxt = ORD_UN;
        end else if (a_inf || b_inf) begin
          ord_nxt = (ri_a < ri_b) ? ORD_LT : ((ri_a > ri_b) ? ORD_GT : ORD_EQ);
        end else if (rf_a != rf_b) begin
          ord_nxt = (rf_a < rf_b) ? ORD_LT : ORD_GT;
        end else if (as_r == '0) begin
          ord_nxt = ORD_EQ;
        end else begin
          // put the larger exponent on the left, scale it toward the right
          if (ae_r < be_r) begin
            ma_nxt   = mag_f(bs_r);
            mb_nxt   = mag_f(as_r);
            d_nxt    = be_r - ae_r;
            flip_nxt = ~as_r[W-1];
            div_din  = PW'(mag_f(as_r));
          end else begin
            ma_nxt   = mag_f(as_r);
            mb_nxt   = mag_f(bs_r);
            d_nxt    = ae_r - be_r;
            flip_nxt = as_r[W-1];
            div_din  = PW'(mag_f(bs_r));
          end
          div_req.start = 1'b1;
          dret_nxt      = S_CML;
          state_nxt     = S_DWAIT;
        end
      end
      // quotient of the right magnitude by ten stays in the divider
      S_CML: begin
        if (d_r == '0) begin
          ord_nxt   = flip_r ? swap_ord(cml_ord) : cml_ord;
          state_nxt = S_DONE;
        end else if (ma_r > dq_w) begin
          ord_nxt   = flip_r ? ORD_LT : ORD_GT;
          state_nxt = S_DONE;
        end else begin
          ma_nxt = ma10;
          d_nxt  = d_r - W'(1);
        end
      end
      // strip trailing zeros, never into the special exponent
      S_NORM: begin
        if ((ns_r == '0) || !(ne_r < EMAX_M1)) begin
          state_nxt = ret_r;
        end else begin
          div_req.start = 1'b1;
          div_din       = PW'(mag_f(ns_r));
          dret_nxt      = S_NORMP;
          state_nxt     = S_DWAIT;
        end
      end
      S_NORMP: begin
        if (div_rsp.rem == 4'd0) begin
          ns_nxt    = sq_n;
          ne_nxt    = ne_r + W'(1);
          state_nxt = S_NORM;
        end else begin
          state_nxt = ret_r;
        end
      end
      S_DWAIT: begin
        if (div_rsp.done) state_nxt = dret_r;
      end
      S_DONE: begin
        if (out_port.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ret_r  <= ret_nxt;
    dret_r <= dret_nxt;
    op_r   <= op_nxt;
    as_r   <= as_nxt;
    ae_r   <= ae_nxt;
    bs_r   <= bs_nxt;
    be_r   <= be_nxt;
    be0_r  <= be0_nxt;
    ns_r   <= ns_nxt;
    ne_r   <= ne_nxt;
    ord_r  <= ord_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    k_r    <= k_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    q_r    <= q_nxt;
    qp_r   <= qp_nxt;
    adj_r  <= adj_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    d_r    <= d_nxt;
    flip_r <= flip_nxt;
  end

  // handshake and result word
  assign in_port.ready          = (state_r == S_IDLE);
  assign out_port.valid         = (state_r == S_DONE);
  assign out_port.r_significand = ns_r;
  assign out_port.r_exponent    = ne_r;
  assign out_port.order         = ord_r;

  // one word in flight: no new word right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_port.ready)
    else $error("word accepted while another is in flight");

  // the divider only reports back while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DWAIT))
    else $error("divider finished outside its wait state");

  // compare gives a zero number
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_port.valid && (op_r == OP_CMP)) |-> ((ns_r == '0) && (ne_r == '0)))
    else $error("compare result carries a nonzero number");

  // arithmetic gives order zero
  a_arith_ord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_port.valid && ((op_r == OP_ADD) || (op_r == OP_SUB) || (op_r == OP_MUL) ||
                        (op_r == OP_DIV))) |-> (out_port.order == ORD_LT))
    else $error("arithmetic result carries an order code");

endmodule

`default_nettype wire
